// ===== hw/rtl/mte_pkg.sv =====
// shared types, constants and symbol table for the base-41 modexp text decryptor
// used by mte_dp, mte_ctrl and base41_modexp_text_decrypt
package mte_pkg;

    localparam int GROUP_CHARS = 6;
    localparam int DROP_PERIOD = 8;
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

    localparam logic [31:0] EXPONENT_RST = 32'd1921821779;
    localparam logic [31:0] MODULUS_RST  = 32'd4294434817;
    localparam logic [5:0]  BASE         = 6'd41;
    localparam logic [7:0]  NEWLINE      = 8'd10;

    // floor(v / 41) == (v * DIV41_MAGIC) >> DIV41_SHIFT for every 32-bit v
    localparam logic [31:0] DIV41_MAGIC  = 32'd3352169597;
    localparam int          DIV41_SHIFT  = 37;

    localparam logic [7:0] SYMBOLS [41] = '{
        8'h20, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
        8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73,
        8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h23, 8'h2E, 8'h2C,
        8'h27, 8'h21, 8'h3F, 8'h28, 8'h29, 8'h2D, 8'h3A, 8'h24, 8'h2F, 8'h26,
        8'h5C
    };

    typedef enum logic [1:0] {MM_REDUCE, MM_SQR, MM_MUL} t_mm_op;
    typedef enum logic [1:0] {OUT_NL, OUT_BAD, OUT_DIGIT} t_out_sel;

    typedef struct packed {
        logic     take;
        logic     mm_start;
        t_mm_op   mm_op;
        logic     ebit_dec;
        logic     div_load;
        logic     div_run;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic is_nl;
        logic is_drop;
        logic is_bad;
        logic completes;
        logic spoiled;
        logic mm_done;
        logic exp_zero;
        logic loop_done;
        logic ebit_set;
        logic digits_full;
        logic emit_last;
        logic out_free;
    } t_stat;

    // {found, index}
    function automatic logic [6:0] sym_lookup(logic [7:0] c);
        logic [6:0] res;
        res = 7'd0;
        for (int i = 0; i < 41; i++) begin
            if (SYMBOLS[i] == c) begin
                res = {1'b1, 6'(i)};
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] sym_char(logic [5:0] d);
        logic [7:0] res;
        res = 8'd0;
        if (d < BASE) begin
            res = SYMBOLS[d];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/base41_modexp_text_decrypt.sv =====
// Decrypts base-41 text one byte per request. Bytes that do not complete a group (newline,
// dropped, bad symbol or partial digit) leave the controller idle. A completed group with
// no bad symbol is processed in order: the group value is reduced, then for each of the 32
// exponent bits a square step runs, plus a multiply for a set bit, on the bit-serial modular
// multiplier (one multiplier bit per cycle), then one base-41 digit per cycle and one result
// per cycle while the receiver does not stall; the exponent loop is skipped when the
// exponent is zero. No new byte is taken during that time. Config writes are always ready.
// top level; instantiates mte_ctrl and mte_dp, uses mte_pkg
module base41_modexp_text_decrypt #(
    parameter int GROUP_CHARS = mte_pkg::GROUP_CHARS,
    parameter int DROP_PERIOD = mte_pkg::DROP_PERIOD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_in_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_out_char,
    output logic                          o_run_last,
    output logic                          o_bad_symbol,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mte_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    mte_pkg::t_cmd  cmd;
    mte_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    mte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mte_dp #(
        .GROUP_CHARS (GROUP_CHARS),
        .DROP_PERIOD (DROP_PERIOD)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_byte    (i_in_byte),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_char   (o_out_char),
        .o_run_last   (o_run_last),
        .o_bad_symbol (o_bad_symbol)
    );

    a_newline_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_byte == mte_pkg::NEWLINE
        |=> o_out_valid && o_out_char == mte_pkg::NEWLINE && o_run_last && !o_bad_symbol)
        else $error("newline request did not produce a newline result");

    a_bad_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_symbol |-> o_out_char == 8'd0 && o_run_last)
        else $error("bad symbol report malformed");

    a_group_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> o_in_stall)
        else $error("input taken while a group is still being emitted");

endmodule

// ===== hw/rtl/mte_dp.sv =====
// datapath: line/group front end, bit-serial modular multiplier, base-41 digit divider,
// output register and config registers; uses mte_pkg
module mte_dp #(
    parameter int GROUP_CHARS = mte_pkg::GROUP_CHARS,
    parameter int DROP_PERIOD = mte_pkg::DROP_PERIOD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mte_pkg::t_cmd                 i_cmd,
    output mte_pkg::t_stat                o_stat,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_cfg_we,
    input  logic [mte_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [7:0]                    o_out_char,
    output logic                          o_run_last,
    output logic                          o_bad_symbol
);

    localparam int PW = $clog2(DROP_PERIOD);

    logic [PW-1:0] r_line_pos;
    logic [2:0]    r_digits;
    logic [31:0]   r_group;
    logic          r_spoiled;
    logic [31:0]   r_exp, r_mod;

    logic [31:0]   r_x, r_y, r_prod, r_base, r_acc;
    logic          r_mm_busy;
    mte_pkg::t_mm_op r_mm_op;
    logic [4:0]    r_cnt;
    logic [4:0]    r_ebit;
    logic          r_loop_done;

    logic [31:0]   r_quo;
    logic [5:0]    r_dig [GROUP_CHARS];
    logic [2:0]    r_dcnt;

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last;
    logic          r_out_bad;

    logic [6:0]    lookup;
    logic          is_bad;
    logic [31:0]   n_group;
    logic [33:0]   n34, t, t1, t2;
    logic [31:0]   mm_res;
    logic          mm_done;
    logic [63:0]   dv_prod;
    logic [31:0]   dv_quo;
    logic [5:0]    dv_rem;
    logic          out_free;

    assign lookup  = mte_pkg::sym_lookup(i_in_byte);
    assign is_bad  = !lookup[6];
    assign n_group = (r_group << 5) + (r_group << 3) + r_group + {26'd0, lookup[5:0]};

    assign n34    = (r_mod == 32'd0) ? 34'h1_0000_0000 : {2'b00, r_mod};
    assign t      = {1'b0, r_prod, 1'b0} + (r_y[31] ? {2'b00, r_x} : 34'd0);
    assign t1     = (t >= n34) ? t - n34 : t;
    assign t2     = (t1 >= n34) ? t1 - n34 : t1;
    assign mm_res = t2[31:0];
    assign mm_done = r_mm_busy && (r_cnt == 5'd31);

    // divide by 41 through reciprocal multiplication, one digit per cycle
    assign dv_prod = {32'd0, r_quo} * {32'd0, mte_pkg::DIV41_MAGIC};
    assign dv_quo  = {5'd0, dv_prod[63:mte_pkg::DIV41_SHIFT]};
    assign dv_rem  = r_quo[5:0] - dv_quo[5:0] * mte_pkg::BASE;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.is_nl       = i_in_byte == mte_pkg::NEWLINE;
        o_stat.is_drop     = r_line_pos == PW'(DROP_PERIOD - 1);
        o_stat.is_bad      = is_bad;
        o_stat.completes   = r_digits == 3'(GROUP_CHARS - 1);
        o_stat.spoiled     = r_spoiled || is_bad;
        o_stat.mm_done     = mm_done;
        o_stat.exp_zero    = r_exp == 32'd0;
        o_stat.loop_done   = r_loop_done;
        o_stat.ebit_set    = r_exp[r_ebit];
        o_stat.digits_full = r_dcnt == 3'(GROUP_CHARS);
        o_stat.emit_last   = r_dcnt == 3'd1;
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos  <= '0;
            r_digits    <= '0;
            r_group     <= '0;
            r_spoiled   <= 1'b0;
            r_exp       <= mte_pkg::EXPONENT_RST;
            r_mod       <= mte_pkg::MODULUS_RST;
            r_mm_busy   <= 1'b0;
            r_loop_done <= 1'b0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mte_pkg::REG_EXPONENT) begin
                    r_exp <= i_cfg_data;
                end else if (i_cfg_index == mte_pkg::REG_MODULUS) begin
                    r_mod <= i_cfg_data;
                end
            end

            // front end
            if (i_cmd.take) begin
                if (o_stat.is_nl) begin
                    r_line_pos <= '0;
                    r_digits   <= '0;
                    r_group    <= '0;
                    r_spoiled  <= 1'b0;
                end else begin
                    r_line_pos <= o_stat.is_drop ? '0 : r_line_pos + PW'(1);
                    if (!o_stat.is_drop) begin
                        if (o_stat.completes) begin
                            r_digits  <= '0;
                            r_group   <= '0;
                            r_spoiled <= 1'b0;
                        end else begin
                            r_digits  <= r_digits + 3'd1;
                            r_group   <= n_group;
                            r_spoiled <= o_stat.spoiled;
                        end
                    end
                end
            end

            // modular multiplier
            if (i_cmd.mm_start) begin
                r_mm_busy <= 1'b1;
                r_mm_op   <= i_cmd.mm_op;
                r_cnt     <= '0;
                r_prod    <= '0;
                case (i_cmd.mm_op)
                    mte_pkg::MM_REDUCE: begin
                        r_x         <= 32'd1;
                        r_y         <= n_group;
                        r_acc       <= (r_exp == 32'd0 || r_mod != 32'd1) ? 32'd1 : 32'd0;
                        r_ebit      <= 5'd31;
                        r_loop_done <= 1'b0;
                    end
                    mte_pkg::MM_SQR: begin
                        r_x <= r_acc;
                        r_y <= r_acc;
                    end
                    default: begin
                        r_x <= r_acc;
                        r_y <= r_base;
                    end
                endcase
            end else if (r_mm_busy) begin
                r_prod <= mm_res;
                r_y    <= r_y << 1;
                r_cnt  <= r_cnt + 5'd1;
                if (mm_done) begin
                    r_mm_busy <= 1'b0;
                    if (r_mm_op == mte_pkg::MM_REDUCE) begin
                        r_base <= mm_res;
                    end else begin
                        r_acc <= mm_res;
                    end
                end
            end

            if (i_cmd.ebit_dec) begin
                if (r_ebit == 5'd0) begin
                    r_loop_done <= 1'b1;
                end else begin
                    r_ebit <= r_ebit - 5'd1;
                end
            end

            // digit divider
            if (i_cmd.div_load) begin
                r_quo  <= r_acc;
                r_dcnt <= '0;
            end else if (i_cmd.div_run) begin
                r_quo  <= dv_quo;
                r_dcnt <= r_dcnt + 3'd1;
                for (int k = 0; k < GROUP_CHARS - 1; k++) begin
                    r_dig[k] <= r_dig[k+1];
                end
                r_dig[GROUP_CHARS-1] <= dv_rem;
            end

            // output register
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                case (i_cmd.out_sel)
                    mte_pkg::OUT_NL: begin
                        r_out_char <= mte_pkg::NEWLINE;
                        r_out_last <= 1'b1;
                        r_out_bad  <= 1'b0;
                    end
                    mte_pkg::OUT_BAD: begin
                        r_out_char <= 8'd0;
                        r_out_last <= 1'b1;
                        r_out_bad  <= 1'b1;
                    end
                    default: begin
                        r_out_char <= mte_pkg::sym_char(r_dig[GROUP_CHARS-1]);
                        r_out_last <= r_dcnt == 3'd1;
                        r_out_bad  <= 1'b0;
                        r_dcnt     <= r_dcnt - 3'd1;
                        for (int k = GROUP_CHARS - 1; k > 0; k--) begin
                            r_dig[k] <= r_dig[k-1];
                        end
                    end
                endcase
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_run_last   = r_out_last;
    assign o_bad_symbol = r_out_bad;

endmodule

// ===== hw/rtl/mte_ctrl.sv =====
// controller: sequences group intake, reduction, square-and-multiply, digit split and emit
// uses mte_pkg command and status structs
module mte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mte_pkg::t_stat i_stat,
    output mte_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_RED, S_LOOP, S_SQR, S_BIT, S_MUL, S_DIV, S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = !(r_state == S_IDLE && i_stat.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mm_op   = mte_pkg::MM_REDUCE;
        o_cmd.out_sel = mte_pkg::OUT_NL;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.is_nl) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = mte_pkg::OUT_NL;
                    end else if (!i_stat.is_drop) begin
                        if (i_stat.is_bad) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = mte_pkg::OUT_BAD;
                        end else if (i_stat.completes && !i_stat.spoiled) begin
                            o_cmd.mm_start = 1'b1;
                            o_cmd.mm_op    = mte_pkg::MM_REDUCE;
                            n_state        = S_RED;
                        end
                    end
                end
            end
            S_RED: begin
                if (i_stat.mm_done) begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_stat.exp_zero || i_stat.loop_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.mm_start = 1'b1;
                    o_cmd.mm_op    = mte_pkg::MM_SQR;
                    n_state        = S_SQR;
                end
            end
            S_SQR: begin
                if (i_stat.mm_done) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (i_stat.ebit_set) begin
                    o_cmd.mm_start = 1'b1;
                    o_cmd.mm_op    = mte_pkg::MM_MUL;
                    n_state        = S_MUL;
                end else begin
                    o_cmd.ebit_dec = 1'b1;
                    n_state        = S_LOOP;
                end
            end
            S_MUL: begin
                if (i_stat.mm_done) begin
                    o_cmd.ebit_dec = 1'b1;
                    n_state        = S_LOOP;
                end
            end
            S_DIV: begin
                if (i_stat.digits_full) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_run = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = mte_pkg::OUT_DIGIT;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for base41_modexp_text_decrypt: directed and random ciphertext
// bytes under several register settings and idling phases, checked by a scoreboard class
// depends on mte_pkg and the base41_modexp_text_decrypt rtl
module tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 3000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } t_plain;

    class plaintext_board;
        t_plain       pending_q[$];
        logic [31:0]  exponent;
        logic [31:0]  modulus;
        int           line_pos;
        int           digits;
        logic [31:0]  group;
        bit           spoiled;
        int           errors;

        function new();
            exponent = mte_pkg::EXPONENT_RST;
            modulus  = mte_pkg::MODULUS_RST;
            line_pos = 0;
            digits   = 0;
            group    = 0;
            spoiled  = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic [mte_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == mte_pkg::REG_EXPONENT) exponent = val;
            else if (idx == mte_pkg::REG_MODULUS) modulus = val;
        endfunction

        function longint unsigned mod_reduce(longint unsigned x);
            if (modulus == 0) return x & 64'hFFFF_FFFF;
            return x % longint'(modulus);
        endfunction

        function longint unsigned mod_power(logic [31:0] a);
            longint unsigned r;
            r = 1;
            if (exponent == 0) return 1;
            for (int b = 31; b >= 0; b--) begin
                r = mod_reduce(r * r);
                if (exponent[b]) r = mod_reduce(r * longint'(a));
            end
            return r;
        endfunction

        function void push(logic [7:0] ch, logic last, logic bad);
            t_plain p;
            p.ch = ch;
            p.last = last;
            p.bad = bad;
            pending_q.push_back(p);
        endfunction

        function void note_input(logic [7:0] c);
            int idx;
            int pos;
            bit was_spoiled;
            longint unsigned v;
            longint unsigned scale;
            longint unsigned d;
            if (c == mte_pkg::NEWLINE) begin
                line_pos = 0;
                digits = 0;
                group = 0;
                spoiled = 0;
                push(mte_pkg::NEWLINE, 1, 0);
                return;
            end
            pos = line_pos;
            line_pos = (pos + 1 >= mte_pkg::DROP_PERIOD) ? 0 : pos + 1;
            if (pos == mte_pkg::DROP_PERIOD - 1) return;
            idx = -1;
            for (int i = 0; i < 41; i++)
                if (mte_pkg::SYMBOLS[i] == c) idx = i;
            group = group * 32'd41 + 32'(idx < 0 ? 0 : idx);
            digits++;
            if (idx < 0) spoiled = 1;
            if (digits >= mte_pkg::GROUP_CHARS) begin
                was_spoiled = spoiled;
                v = mod_power(group);
                digits = 0;
                group = 0;
                spoiled = 0;
                if (idx < 0) begin
                    push(8'd0, 1, 1);
                    return;
                end
                if (was_spoiled) return;
                scale = 1;
                for (int k = 0; k < mte_pkg::GROUP_CHARS; k++) scale *= 41;
                v %= scale;
                for (int k = 0; k < mte_pkg::GROUP_CHARS; k++) begin
                    scale /= 41;
                    d = v / scale;
                    v -= d * scale;
                    push(mte_pkg::SYMBOLS[d % 41], k == mte_pkg::GROUP_CHARS - 1, 0);
                end
                return;
            end
            if (idx < 0) push(8'd0, 1, 1);
        endfunction

        function void check(logic [7:0] ch, logic last, logic bad);
            t_plain e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result char %h last %b bad %b", $time, ch, last, bad);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (e.ch !== ch || e.last !== last || e.bad !== bad) begin
                $display("%0t: mismatch expected char %h last %b bad %b, got %h %b %b",
                         $time, e.ch, e.last, e.bad, ch, last, bad);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [7:0]                    i_in_byte;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [7:0]                    o_out_char;
    logic                          o_run_last;
    logic                          o_bad_symbol;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [mte_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;

    plaintext_board board;
    int  cycles;
    int  tx_pct;
    int  rx_pct;
    bit  hold_req;
    int  hold_left;

    base41_modexp_text_decrypt DUT (.*);

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte = 8'd0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = mte_pkg::REG_EXPONENT;
        i_cfg_data = 32'd0;
        cycles = 0;
        tx_pct = 0;
        rx_pct = 0;
        hold_req = 0;
        hold_left = 0;
        board = new();
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // input and output monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_input(i_in_byte);
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check(o_out_char, o_run_last, o_bad_symbol);
    end

    // receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 8000;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [mte_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 4) return mte_pkg::NEWLINE;
        if (r < 10) return 8'($urandom_range(255));
        return mte_pkg::SYMBOLS[$urandom_range(40)];
    endfunction

    task automatic run_phase(logic [31:0] e, logic [31:0] m, int tx, int rx, bit press, int n);
        write_reg(mte_pkg::REG_EXPONENT, e);
        write_reg(mte_pkg::REG_MODULUS, m);
        i_cfg_valid <= 1'b0;
        tx_pct = tx;
        rx_pct = rx;
        if (press) hold_req = 1;
        for (int i = 0; i < n; i++) send_byte(pick_byte());
        send_byte(mte_pkg::NEWLINE);
        drain();
    endtask

    initial begin
        logic [7:0] directed[$];
        #1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero group, all-backslash group across a dropped byte, spoiled groups
        directed = '{8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
                     8'h5C, 8'hFF, 8'h5C, 8'h5C, 8'h5C, 8'h5C, 8'h5C, mte_pkg::NEWLINE,
                     8'h61, 8'h62, 8'h00, 8'h63, 8'h64, 8'h65,
                     8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h80, mte_pkg::NEWLINE};
        foreach (directed[i]) send_byte(directed[i]);
        drain();

        run_phase(32'd0, $urandom, 82, 0, 0, 18);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 82, 0, 18);
        run_phase($urandom, 32'd0, 6, 6, 0, 18);
        run_phase(32'd3, 32'd1, 0, 0, 1, 18);
        run_phase(32'd0, 32'd1, 82, 0, 0, 18);
        run_phase($urandom, 32'd2, 0, 82, 0, 18);
        run_phase($urandom, $urandom, 0, 0, 0, 18);

        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
